>>> sv/tbe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tbe_pkg;

  localparam int MaxParamDims = 3;
  localparam int MaxDegree    = 7;
  localparam int MaxKnots     = 64;
  localparam int CtrlPoints   = 4096;
  localparam int MaxCtrlDims  = 4;

  localparam int KnotDepth = MaxParamDims * MaxKnots;
  localparam int CtrlDepth = CtrlPoints * MaxCtrlDims;
  localparam int KnotAw    = $clog2(KnotDepth);
  localparam int CtrlAw    = $clog2(CtrlDepth);

  localparam logic signed [31:0] QOne   = 32'sh0001_0000;
  localparam logic signed [31:0] QMax   = 32'sh7fff_ffff;
  localparam logic signed [31:0] QMin   = 32'sh8000_0000;

  typedef enum logic [1:0] {
    CMD_KNOT = 2'd0,
    CMD_CTRL = 2'd1,
    CMD_EVAL = 2'd2,
    CMD_NONE = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    REG_PARAM_DIMS = 3'd0,
    REG_CTRL_DIMS  = 3'd1,
    REG_DEGREE0    = 3'd2,
    REG_DEGREE1    = 3'd3,
    REG_DEGREE2    = 3'd4,
    REG_KNOTS0     = 3'd5,
    REG_KNOTS1     = 3'd6,
    REG_KNOTS2     = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    JOB_KNOT = 2'd0,
    JOB_CTRL = 2'd1,
    JOB_EVAL = 2'd2
  } job_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LO,
    ST_HI,
    ST_CHK,
    ST_M_RD,
    ST_M_CHK,
    ST_SPAN,
    ST_SP_RD,
    ST_SP_CHK,
    ST_DB_INIT,
    ST_T_RD1,
    ST_T_RD2,
    ST_T_DIV,
    ST_T_DWT,
    ST_T_MUL,
    ST_T_ACC,
    ST_DIM_END,
    ST_ACC_INIT,
    ST_W1,
    ST_W2,
    ST_W3,
    ST_W4,
    ST_C_RD,
    ST_C_MUL,
    ST_C_ACC,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [1:0]         command;
    logic [1:0]         dim_index;
    logic [11:0]        entry_index;
    logic [1:0]         component;
    logic signed [31:0] load_value;
    logic signed [31:0] coord_0;
    logic signed [31:0] coord_1;
    logic signed [31:0] coord_2;
  } req_t;

  typedef struct packed {
    logic signed [31:0] point_0;
    logic signed [31:0] point_1;
    logic signed [31:0] point_2;
    logic signed [31:0] point_3;
    logic               status;
  } res_t;

  typedef struct packed {
    logic [1:0]       param_dims;
    logic [2:0]       ctrl_dims;
    logic [2:0][2:0]  degree;
    logic [2:0][6:0]  knots;
  } cfg_t;

  typedef struct packed {
    job_e               kind;
    logic [CtrlAw-1:0]  addr;
    logic [31:0]        value;
    logic [2:0][31:0]   coord;
  } job_t;

  // Product of two Q16.16 values, floored to Q16.16 and saturated.
  function automatic logic signed [31:0] q_shift(input logic signed [63:0] p);
    logic signed [63:0] s;
    s = p >>> 16;
    if (s > 64'sh0000_0000_7fff_ffff) begin
      return QMax;
    end else if (s < -64'sh0000_0000_8000_0000) begin
      return QMin;
    end
    return s[31:0];
  endfunction

  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    if (v[32] != v[31]) begin
      return v[32] ? QMin : QMax;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] sat48(input logic signed [47:0] v);
    if (v > 48'sh0000_7fff_ffff) begin
      return QMax;
    end else if (v < -48'sh0000_8000_0000) begin
      return QMin;
    end
    return v[31:0];
  endfunction

  // Position in the unpadded knot list of padded knot i.
  function automatic logic [5:0] knot_pos(input logic [7:0] i, input logic [2:0] p,
                                         input logic [6:0] n);
    logic [7:0] ip;
    logic [6:0] last;
    ip   = i - {5'b0, p};
    last = n - 7'd1;
    if (i < {5'b0, p}) begin
      return 6'd0;
    end else if (ip < {1'b0, n}) begin
      return ip[5:0];
    end
    return last[5:0];
  endfunction

endpackage

`default_nettype wire

>>> sv/tbe_div.sv
`timescale 1ns / 1ps
`default_nettype none

module tbe_div (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [32:0] num_i,
  input  wire logic signed [32:0] den_i,
  output logic                    done_o,
  output logic signed [31:0]      quo_o
);
  import tbe_pkg::*;

  localparam int DvdW  = 49;
  localparam int CntW  = $clog2(DvdW + 1);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic            neg_q, neg_d;
  logic            zero_q, zero_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [32:0]     rem_q, rem_d;
  logic [DvdW-1:0] dvd_q, dvd_d;
  logic [32:0]     dmag_q, dmag_d;
  logic [32:0]     nmag, dmag_in;
  logic [33:0]     rem_sh;

  assign nmag    = num_i[32] ? 33'(-num_i) : num_i;
  assign dmag_in = den_i[32] ? 33'(-den_i) : den_i;
  assign rem_sh  = {rem_q, dvd_q[DvdW-1]};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    neg_d  = neg_q;
    zero_d = zero_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    dmag_d = dmag_q;
    if (start_i) begin
      busy_d = 1'b1;
      neg_d  = num_i[32] ^ den_i[32];
      zero_d = (den_i == '0);
      cnt_d  = CntW'(DvdW);
      rem_d  = '0;
      dvd_d  = {nmag, 16'b0};
      dmag_d = dmag_in;
    end else if (busy_q) begin
      // One restoring step per cycle.
      if (rem_sh >= {1'b0, dmag_q}) begin
        rem_d = 33'(rem_sh - {1'b0, dmag_q});
        dvd_d = {dvd_q[DvdW-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[32:0];
        dvd_d = {dvd_q[DvdW-2:0], 1'b0};
      end
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q  <= neg_d;
    zero_q <= zero_d;
    cnt_q  <= cnt_d;
    rem_q  <= rem_d;
    dvd_q  <= dvd_d;
    dmag_q <= dmag_d;
  end

  always_comb begin
    if (zero_q) begin
      quo_o = '0;
    end else if (neg_q) begin
      quo_o = (dvd_q > DvdW'(33'h0_8000_0000)) ? QMin : 32'(~dvd_q[31:0] + 32'd1);
    end else begin
      quo_o = (dvd_q > DvdW'(33'h0_7fff_ffff)) ? QMax : dvd_q[31:0];
    end
  end

  assign done_o = done_q;

endmodule

`default_nettype wire

>>> sv/tbe_front.sv
`timescale 1ns / 1ps
`default_nettype none

module tbe_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push,
  output logic               full,
  input  wire tbe_pkg::req_t req_i,
  output logic               job_valid_o,
  output tbe_pkg::job_t      job_o,
  input  wire logic          job_pop_i
);
  import tbe_pkg::*;

  job_t       fifo_q [2];
  job_t       fifo_d [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       keep;
  job_t       job;
  logic       wr_en, rd_en;

  // Decode the request; loads that fall outside the stores and the empty
  // command are dropped here and never reach the back end.
  always_comb begin
    keep       = 1'b0;
    job.kind   = JOB_EVAL;
    job.addr   = '0;
    job.value  = req_i.load_value;
    job.coord  = {req_i.coord_2, req_i.coord_1, req_i.coord_0};
    unique case (cmd_e'(req_i.command))
      CMD_KNOT: begin
        keep     = (32'(req_i.dim_index) < MaxParamDims) &&
                   (32'(req_i.entry_index) < MaxKnots);
        job.kind = JOB_KNOT;
        job.addr = CtrlAw'({req_i.dim_index, req_i.entry_index[5:0]});
      end
      CMD_CTRL: begin
        keep     = (32'(req_i.entry_index) < CtrlPoints) &&
                   (32'(req_i.component) < MaxCtrlDims);
        job.kind = JOB_CTRL;
        job.addr = {req_i.entry_index, req_i.component};
      end
      CMD_EVAL: begin
        keep     = 1'b1;
        job.kind = JOB_EVAL;
      end
      default: keep = 1'b0;
    endcase
  end

  assign full  = (cnt_q == 2'd2);
  assign wr_en = push && !full && keep;
  assign rd_en = job_pop_i && (cnt_q != 2'd0);

  always_comb begin
    fifo_d   = fifo_q;
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en) begin
      fifo_d[wr_ptr_q] = job;
      wr_ptr_d         = !wr_ptr_q;
    end
    if (rd_en) begin
      rd_ptr_d = !rd_ptr_q;
    end
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!wr_en && rd_en) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fifo_q <= fifo_d;
  end

  assign job_valid_o = (cnt_q != 2'd0);
  assign job_o       = fifo_q[rd_ptr_q];

endmodule

`default_nettype wire

>>> sv/tbe_back.sv
`timescale 1ns / 1ps
`default_nettype none

module tbe_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire tbe_pkg::cfg_t cfg_i,
  input  wire logic          job_valid_i,
  input  wire tbe_pkg::job_t job_i,
  output logic               job_pop_o,
  output logic               res_valid_o,
  output tbe_pkg::res_t      res_o,
  input  wire logic          res_pop_i
);
  import tbe_pkg::*;

  logic [31:0] knot_mem [KnotDepth];
  logic [31:0] ctrl_mem [CtrlDepth];
  logic signed [31:0] knot_rd_q, ctrl_rd_q;
  logic [KnotAw-1:0] knot_raddr;
  logic knot_we, ctrl_we;

  state_e state_q, state_d;

  logic signed [31:0] u_q [3], u_d [3];
  logic [1:0] s_q, s_d;
  logic signed [31:0] lo_q, lo_d, hi_q, hi_d;
  logic [5:0] m_q, m_d;
  logic [6:0] j_q, j_d, i_q, i_d;
  logic [2:0] q_q, q_d, idx_q, idx_d;
  logic side_q, side_d;
  logic signed [31:0] x1_q, x1_d, sum_q, sum_d, ratio_q, ratio_d;
  logic signed [63:0] prod_q, prod_d;
  logic signed [31:0] b_q [8], b_d [8];
  logic signed [31:0] bas_q [3][8], bas_d [3][8];
  logic [2:0] deg_q [3], deg_d [3];
  logic [6:0] first_q [3], first_d [3], nc_q [3], nc_d [3];
  logic [2:0] ia_q, ia_d, ib_q, ib_d, ic_q, ic_d;
  logic [1:0] r_q, r_d;
  logic signed [31:0] w1_q, w1_d, w_q, w_d;
  logic [12:0] fa_q, fa_d;
  logic [18:0] flat_q, flat_d;
  logic signed [47:0] acc_q [4], acc_d [4];
  logic bad_q, bad_d;
  res_t res_q, res_d;
  logic res_valid_q, res_valid_d;

  logic [1:0] pd;
  logic [2:0] cd, p_cur;
  logic [6:0] n_cur, l_cur;
  logic signed [31:0] u_cur;
  logic [7:0] ii;
  logic [2:0] bidx;
  logic signed [31:0] term;
  logic signed [32:0] total;
  logic div_start, div_done;
  logic signed [32:0] div_num, div_den;
  logic signed [31:0] div_quo;
  logic [6:0] pos0, pos1, pos2;
  logic last_r, eval_go;

  // Configuration as the datapath sees it.
  always_comb begin
    pd    = (cfg_i.param_dims == 2'd0) ? 2'd1 : cfg_i.param_dims;
    cd    = (cfg_i.ctrl_dims == 3'd0) ? 3'd1 :
            (cfg_i.ctrl_dims > 3'(MaxCtrlDims)) ? 3'(MaxCtrlDims) : cfg_i.ctrl_dims;
    p_cur = cfg_i.degree[s_q];
    n_cur = (cfg_i.knots[s_q] < 7'd2) ? 7'd2 :
            (cfg_i.knots[s_q] > 7'(MaxKnots)) ? 7'(MaxKnots) : cfg_i.knots[s_q];
  end

  assign u_cur  = u_q[s_q];
  assign l_cur  = {1'b0, m_q} + {4'b0, p_cur};
  assign ii     = {1'b0, j_q} - {5'b0, p_cur} + {5'b0, idx_q};
  assign bidx   = idx_q + {2'b0, side_q};
  assign term   = q_shift(prod_q);
  assign total  = {sum_q[31], sum_q} + {term[31], term};
  assign pos0   = first_q[0] + {4'b0, ia_q};
  assign pos1   = first_q[1] + {4'b0, ib_q};
  assign pos2   = first_q[2] + {4'b0, ic_q};
  assign last_r = ({1'b0, r_q} + 3'd1) >= cd;
  assign eval_go = job_valid_i && ((job_i.kind != JOB_EVAL) || !res_valid_q);

  assign div_start = (state_q == ST_T_DIV);
  assign div_num   = side_q ? 33'({knot_rd_q[31], knot_rd_q} - {u_cur[31], u_cur})
                            : 33'({u_cur[31], u_cur} - {x1_q[31], x1_q});
  assign div_den   = 33'({knot_rd_q[31], knot_rd_q} - {x1_q[31], x1_q});

  tbe_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // Knot read address for the states that fetch a knot.
  always_comb begin
    knot_raddr = {s_q, 6'd0};
    case (state_q)
      ST_HI:    knot_raddr = {s_q, 6'(n_cur - 7'd1)};
      ST_M_RD:  knot_raddr = {s_q, m_q};
      ST_SP_RD: knot_raddr = {s_q, knot_pos({1'b0, i_q}, p_cur, n_cur)};
      ST_T_RD1: knot_raddr = {s_q, knot_pos(ii + {7'b0, side_q}, p_cur, n_cur)};
      ST_T_RD2: knot_raddr = {s_q, knot_pos(ii + {5'b0, q_q} + {7'b0, side_q},
                                            p_cur, n_cur)};
      default:  knot_raddr = {s_q, 6'd0};
    endcase
  end

  assign knot_we = (state_q == ST_IDLE) && eval_go && (job_i.kind == JOB_KNOT);
  assign ctrl_we = (state_q == ST_IDLE) && eval_go && (job_i.kind == JOB_CTRL);

  always_ff @(posedge clk_i) begin
    if (knot_we) begin
      knot_mem[job_i.addr[KnotAw-1:0]] <= job_i.value;
    end
    knot_rd_q <= knot_mem[knot_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_we) begin
      ctrl_mem[job_i.addr] <= job_i.value;
    end
    ctrl_rd_q <= ctrl_mem[{flat_q[11:0], r_q}];
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (eval_go && (job_i.kind == JOB_EVAL)) begin
          state_d = ST_LO;
        end
      end
      ST_LO:  state_d = ST_HI;
      ST_HI:  state_d = ST_CHK;
      ST_CHK: begin
        if ((lo_q >= knot_rd_q) || (u_cur < lo_q) || (u_cur > knot_rd_q)) begin
          state_d = ST_FINISH;
        end else begin
          state_d = ST_M_RD;
        end
      end
      ST_M_RD:  state_d = (m_q == 6'd0) ? ST_SPAN : ST_M_CHK;
      ST_M_CHK: state_d = (knot_rd_q == hi_q) ? ST_M_RD : ST_SPAN;
      ST_SPAN:  state_d = (u_cur == hi_q) ? ST_DB_INIT : ST_SP_RD;
      ST_SP_RD: state_d = ST_SP_CHK;
      ST_SP_CHK: state_d = (i_q == l_cur) ? ST_DB_INIT : ST_SP_RD;
      ST_DB_INIT: state_d = (p_cur == 3'd0) ? ST_DIM_END : ST_T_RD1;
      ST_T_RD1: state_d = ST_T_RD2;
      ST_T_RD2: state_d = ST_T_DIV;
      ST_T_DIV: state_d = ST_T_DWT;
      ST_T_DWT: state_d = div_done ? ST_T_MUL : ST_T_DWT;
      ST_T_MUL: state_d = ST_T_ACC;
      ST_T_ACC: begin
        if ((idx_q == p_cur) && (q_q == p_cur) && (side_q || (idx_q == p_cur))) begin
          state_d = ST_DIM_END;
        end else begin
          state_d = ST_T_RD1;
        end
      end
      ST_DIM_END: begin
        state_d = ({1'b0, s_q} + 3'd1 < {1'b0, pd}) ? ST_LO : ST_ACC_INIT;
      end
      ST_ACC_INIT: state_d = ST_W1;
      ST_W1: state_d = ST_W2;
      ST_W2: state_d = ST_W3;
      ST_W3: state_d = ST_W4;
      ST_W4: state_d = ST_C_RD;
      ST_C_RD: state_d = ST_C_MUL;
      ST_C_MUL: state_d = ST_C_ACC;
      ST_C_ACC: begin
        if (!last_r) begin
          state_d = ST_C_RD;
        end else if (ic_q < deg_q[2]) begin
          state_d = ST_W3;
        end else if ((ib_q < deg_q[1]) || (ia_q < deg_q[0])) begin
          state_d = ST_W1;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Datapath registers.
  always_comb begin
    u_d = u_q;  s_d = s_q;  lo_d = lo_q;  hi_d = hi_q;  m_d = m_q;
    j_d = j_q;  i_d = i_q;  q_d = q_q;  idx_d = idx_q;  side_d = side_q;
    x1_d = x1_q;  sum_d = sum_q;  ratio_d = ratio_q;  prod_d = prod_q;
    b_d = b_q;  bas_d = bas_q;  deg_d = deg_q;  first_d = first_q;  nc_d = nc_q;
    ia_d = ia_q;  ib_d = ib_q;  ic_d = ic_q;  r_d = r_q;
    w1_d = w1_q;  w_d = w_q;  fa_d = fa_q;  flat_d = flat_q;
    acc_d = acc_q;  bad_d = bad_q;  res_d = res_q;  res_valid_d = res_valid_q;
    job_pop_o = 1'b0;

    if (res_pop_i && res_valid_q) begin
      res_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (eval_go) begin
          job_pop_o = 1'b1;
          if (job_i.kind == JOB_EVAL) begin
            for (int d = 0; d < 3; d++) begin
              u_d[d]     = job_i.coord[d];
              deg_d[d]   = 3'd0;
              first_d[d] = 7'd0;
              nc_d[d]    = 7'd1;
              for (int k = 0; k < 8; k++) begin
                bas_d[d][k] = (k == 0) ? QOne : '0;
              end
            end
            s_d   = 2'd0;
            bad_d = 1'b0;
          end
        end
      end
      ST_HI: lo_d = knot_rd_q;
      ST_CHK: begin
        hi_d = knot_rd_q;
        m_d  = 6'(n_cur - 7'd2);
        if ((lo_q >= knot_rd_q) || (u_cur < lo_q) || (u_cur > knot_rd_q)) begin
          bad_d = 1'b1;
        end
      end
      ST_M_CHK: begin
        if (knot_rd_q == hi_q) begin
          m_d = m_q - 6'd1;
        end
      end
      ST_SPAN: begin
        // A point on the upper edge takes the highest non-empty span.
        if (u_cur == hi_q) begin
          j_d = l_cur;
        end else begin
          j_d = {4'b0, p_cur};
          i_d = {4'b0, p_cur};
        end
      end
      ST_SP_CHK: begin
        if (knot_rd_q <= u_cur) begin
          j_d = i_q;
        end
        i_d = i_q + 7'd1;
      end
      ST_DB_INIT: begin
        for (int k = 0; k < 8; k++) begin
          b_d[k] = (3'(k) == p_cur) ? QOne : '0;
        end
        q_d    = 3'd1;
        idx_d  = p_cur - 3'd1;
        side_d = 1'b1;
        sum_d  = '0;
      end
      ST_T_RD2: x1_d = knot_rd_q;
      ST_T_DWT: ratio_d = div_quo;
      ST_T_MUL: prod_d = ratio_q * b_q[bidx];
      ST_T_ACC: begin
        if (!side_q && (idx_q != p_cur)) begin
          sum_d  = term;
          side_d = 1'b1;
        end else begin
          // In-place update: later entries read only higher positions.
          b_d[idx_q] = sat33(total);
          sum_d      = '0;
          if (idx_q == p_cur) begin
            q_d    = q_q + 3'd1;
            idx_d  = p_cur - (q_q + 3'd1);
            side_d = 1'b1;
          end else begin
            idx_d  = idx_q + 3'd1;
            side_d = 1'b0;
          end
        end
      end
      ST_DIM_END: begin
        bas_d[s_q]   = b_q;
        deg_d[s_q]   = p_cur;
        first_d[s_q] = j_q - {4'b0, p_cur};
        nc_d[s_q]    = n_cur + {4'b0, p_cur} - 7'd1;
        s_d          = s_q + 2'd1;
      end
      ST_ACC_INIT: begin
        ia_d = 3'd0;
        ib_d = 3'd0;
        ic_d = 3'd0;
        for (int k = 0; k < 4; k++) begin
          acc_d[k] = '0;
        end
      end
      ST_W1: prod_d = bas_q[0][ia_q] * bas_q[1][ib_q];
      ST_W2: w1_d = q_shift(prod_q);
      ST_W3: begin
        prod_d = w1_q * bas_q[2][ic_q];
        fa_d   = 13'({6'b0, pos0} * {6'b0, nc_q[1]}) + {6'b0, pos1};
      end
      ST_W4: begin
        w_d    = q_shift(prod_q);
        flat_d = 19'({6'b0, fa_q} * {12'b0, nc_q[2]}) + {12'b0, pos2};
        r_d    = 2'd0;
      end
      ST_C_MUL: begin
        // Control points beyond the store read as zero.
        prod_d = w_q * ((flat_q[18:12] == '0) ? ctrl_rd_q : 32'sd0);
      end
      ST_C_ACC: begin
        acc_d[r_q] = acc_q[r_q] + {{16{term[31]}}, term};
        if (!last_r) begin
          r_d = r_q + 2'd1;
        end else if (ic_q < deg_q[2]) begin
          ic_d = ic_q + 3'd1;
        end else if (ib_q < deg_q[1]) begin
          ib_d = ib_q + 3'd1;
          ic_d = 3'd0;
        end else if (ia_q < deg_q[0]) begin
          ia_d = ia_q + 3'd1;
          ib_d = 3'd0;
          ic_d = 3'd0;
        end
      end
      ST_FINISH: begin
        res_d.point_0 = (bad_q || (cd <= 3'd0)) ? '0 : sat48(acc_q[0]);
        res_d.point_1 = (bad_q || (cd <= 3'd1)) ? '0 : sat48(acc_q[1]);
        res_d.point_2 = (bad_q || (cd <= 3'd2)) ? '0 : sat48(acc_q[2]);
        res_d.point_3 = (bad_q || (cd <= 3'd3)) ? '0 : sat48(acc_q[3]);
        res_d.status  = bad_q;
        res_valid_d   = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    u_q <= u_d;  s_q <= s_d;  lo_q <= lo_d;  hi_q <= hi_d;  m_q <= m_d;
    j_q <= j_d;  i_q <= i_d;  q_q <= q_d;  idx_q <= idx_d;  side_q <= side_d;
    x1_q <= x1_d;  sum_q <= sum_d;  ratio_q <= ratio_d;  prod_q <= prod_d;
    b_q <= b_d;  bas_q <= bas_d;  deg_q <= deg_d;  first_q <= first_d;  nc_q <= nc_d;
    ia_q <= ia_d;  ib_q <= ib_d;  ic_q <= ic_d;  r_q <= r_d;
    w1_q <= w1_d;  w_q <= w_d;  fa_q <= fa_d;  flat_q <= flat_d;
    acc_q <= acc_d;  bad_q <= bad_d;  res_q <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

>>> sv/tensor_bspline_evaluator.sv
// A load request is written to its store once the idle back end takes it from the queue.
// An evaluate request runs a span search and a basis table for each dimension, whose
// ratios come from the 49-step divider, then accumulates every tensor term per component.
// One request is worked on at a time; a two-entry queue and a result register
// let push and pop proceed while the back end is busy.
// Reset clears control state and loads the configuration defaults; the stores hold garbage.
`timescale 1ns / 1ps
`default_nettype none

module tensor_bspline_evaluator (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  // Request side.
  input  wire logic          push,
  output logic               full,
  input  wire tbe_pkg::req_t req_i,
  // Result side.
  output logic               empty,
  input  wire logic          pop,
  output tbe_pkg::res_t      res_o,
  // Configuration port.
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [4:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import tbe_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic cfg_we;
  cfg_reg_e cfg_idx;
  logic job_valid, job_pop, res_valid;
  job_t job;

  // The configuration registers. Writes complete in the access phase; the
  // port never inserts wait states.
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign cfg_idx = cfg_reg_e'(paddr[4:2]);

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we) begin
      unique case (cfg_idx)
        REG_PARAM_DIMS: cfg_d.param_dims = pwdata[1:0];
        REG_CTRL_DIMS:  cfg_d.ctrl_dims  = pwdata[2:0];
        REG_DEGREE0:    cfg_d.degree[0]  = pwdata[2:0];
        REG_DEGREE1:    cfg_d.degree[1]  = pwdata[2:0];
        REG_DEGREE2:    cfg_d.degree[2]  = pwdata[2:0];
        REG_KNOTS0:     cfg_d.knots[0]   = pwdata[6:0];
        REG_KNOTS1:     cfg_d.knots[1]   = pwdata[6:0];
        REG_KNOTS2:     cfg_d.knots[2]   = pwdata[6:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_PARAM_DIMS: prdata = {30'b0, cfg_q.param_dims};
      REG_CTRL_DIMS:  prdata = {29'b0, cfg_q.ctrl_dims};
      REG_DEGREE0:    prdata = {29'b0, cfg_q.degree[0]};
      REG_DEGREE1:    prdata = {29'b0, cfg_q.degree[1]};
      REG_DEGREE2:    prdata = {29'b0, cfg_q.degree[2]};
      REG_KNOTS0:     prdata = {25'b0, cfg_q.knots[0]};
      REG_KNOTS1:     prdata = {25'b0, cfg_q.knots[1]};
      REG_KNOTS2:     prdata = {25'b0, cfg_q.knots[2]};
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.param_dims <= 2'd1;
      cfg_q.ctrl_dims  <= 3'd1;
      cfg_q.degree     <= '0;
      cfg_q.knots      <= {7'd2, 7'd2, 7'd2};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // The front end decodes each request and queues it for the back end.
  tbe_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .req_i       (req_i),
    .job_valid_o (job_valid),
    .job_o       (job),
    .job_pop_i   (job_pop)
  );

  // The back end owns both stores, runs the span search, the basis table and
  // the tensor sum, and holds the finished result until it is popped.
  tbe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_valid_i (job_valid),
    .job_i       (job),
    .job_pop_o   (job_pop),
    .res_valid_o (res_valid),
    .res_o       (res_o),
    .res_pop_i   (pop)
  );

  assign empty = !res_valid;

endmodule

`default_nettype wire

>>> dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import tbe_pkg::*;

  localparam int StallLimit = 150000;

  // Clock, reset and the ports of the block.
  logic        clk_i;
  logic        rst_ni;
  logic        push;
  logic        full;
  req_t        req_i;
  logic        empty;
  logic        pop;
  res_t        res_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  tensor_bspline_evaluator i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push    (push),
    .full    (full),
    .req_i   (req_i),
    .empty   (empty),
    .pop     (pop),
    .res_o   (res_o),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow copy of the block: both stores, a record of which control points have
  // been written, and the configuration registers as they were last written.
  logic signed [31:0] knot_mem [KnotDepth];
  logic signed [31:0] ctrl_mem [CtrlDepth];
  bit                 ctrl_written [CtrlPoints];
  int                 cfg_val [8] = '{1, 1, 0, 0, 0, 2, 2, 2};
  int                 cfg_mask [8] = '{3, 7, 7, 7, 7, 127, 127, 127};

  res_t  spline_values [$];   // results still owed by the block, oldest first
  int    unwritten_points [$];
  int    errors;
  int    requests_sent;
  bit    jitter;
  int    hold_request;
  int    idle_count;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Fixed-point helpers. The ratio truncates towards zero, the product floors.
  function automatic longint clip32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint q_div(input longint num, input longint den);
    if (den == 0) return 0;
    return clip32((num * 65536) / den);
  endfunction

  function automatic longint q_prod(input longint a, input longint b);
    longint pr;
    pr = a * b;
    return clip32(pr >>> 16);
  endfunction

  // Knot i of the clamped vector, the end knots being repeated p times.
  function automatic longint padded_knot(input int s, input int i, input int n, input int p);
    int ix;
    if (i < p) ix = 0;
    else if (i < p + n) ix = i - p;
    else ix = n - 1;
    return longint'(knot_mem[s * MaxKnots + ix]);
  endfunction

  // Works out the spline value at the point of an evaluate request. Any control
  // point that the sum would read before it has been written is noted, so that
  // the sender can load it first.
  function automatic res_t evaluate_point(input req_t r);
    int     pd, cd, p, n, m, l, j, q, ix, ii, s, k, a, b, c, i;
    int     deg [3], first [3], nc [3];
    longint basis [3][8];
    longint bv [8], cv [8];
    longint coord [3], acc [4];
    longint u, lo, hi, w0, w1, w, cval, ta, tb, tc, td, flat;
    bit     bad;
    res_t   res;
    pd = (cfg_val[REG_PARAM_DIMS] < 1) ? 1 : cfg_val[REG_PARAM_DIMS];
    if (pd > MaxParamDims) pd = MaxParamDims;
    cd = (cfg_val[REG_CTRL_DIMS] < 1) ? 1 : cfg_val[REG_CTRL_DIMS];
    if (cd > MaxCtrlDims) cd = MaxCtrlDims;
    coord[0] = r.coord_0;
    coord[1] = r.coord_1;
    coord[2] = r.coord_2;
    bad = 1'b0;
    for (s = 0; s < 3; s++) begin
      deg[s] = 0;
      first[s] = 0;
      nc[s] = 1;
      for (k = 0; k < 8; k++) basis[s][k] = 0;
      basis[s][0] = QOne;
    end
    for (s = 0; s < pd; s++) begin
      p = cfg_val[REG_DEGREE0 + s];
      n = cfg_val[REG_KNOTS0 + s];
      if (n < 2) n = 2;
      if (n > MaxKnots) n = MaxKnots;
      u = coord[s];
      lo = knot_mem[s * MaxKnots];
      hi = knot_mem[s * MaxKnots + n - 1];
      if (lo >= hi || u < lo || u > hi) begin
        bad = 1'b1;
        break;
      end
      m = n - 2;
      while (m > 0 && longint'(knot_mem[s * MaxKnots + m]) == hi) m--;
      l = m + p;
      j = p;
      if (u == hi) begin
        j = l;
      end else begin
        for (i = p; i <= l; i++) if (padded_knot(s, i, n, p) <= u) j = i;
      end
      // Bottom-up triangle: each pass widens the nonzero basis by one entry.
      for (k = 0; k < 8; k++) bv[k] = 0;
      bv[p] = QOne;
      for (q = 1; q <= p; q++) begin
        ta = padded_knot(s, j + 1, n, p);
        cv[p - q] = q_prod(q_div(ta - u, ta - padded_knot(s, j - q + 1, n, p)), bv[p - q + 1]);
        for (ix = p - q + 1; ix < p; ix++) begin
          ii = j - p + ix;
          ta = padded_knot(s, ii, n, p);
          tb = padded_knot(s, ii + q, n, p);
          tc = padded_knot(s, ii + 1, n, p);
          td = padded_knot(s, ii + q + 1, n, p);
          cv[ix] = clip32(q_prod(q_div(u - ta, tb - ta), bv[ix])
                        + q_prod(q_div(td - u, td - tc), bv[ix + 1]));
        end
        ta = padded_knot(s, j, n, p);
        cv[p] = q_prod(q_div(u - ta, padded_knot(s, j + q, n, p) - ta), bv[p]);
        for (k = p - q; k <= p; k++) bv[k] = cv[k];
      end
      for (k = 0; k <= p; k++) basis[s][k] = bv[k];
      deg[s] = p;
      first[s] = j - p;
      nc[s] = n + p - 1;
    end
    for (k = 0; k < 4; k++) acc[k] = 0;
    if (!bad) begin
      for (a = 0; a <= deg[0]; a++) begin
        w0 = q_prod(QOne, basis[0][a]);
        for (b = 0; b <= deg[1]; b++) begin
          w1 = q_prod(w0, basis[1][b]);
          for (c = 0; c <= deg[2]; c++) begin
            w = q_prod(w1, basis[2][c]);
            flat = (longint'(first[0] + a) * nc[1] + (first[1] + b)) * nc[2] + (first[2] + c);
            if (flat < CtrlPoints && !ctrl_written[flat]) unwritten_points.push_back(int'(flat));
            for (k = 0; k < cd; k++) begin
              cval = 0;
              if (flat < CtrlPoints) cval = ctrl_mem[flat * MaxCtrlDims + k];
              acc[k] += q_prod(w, cval);
            end
          end
        end
      end
    end
    for (k = 0; k < 4; k++) acc[k] = (bad || k >= cd) ? 0 : clip32(acc[k]);
    res.point_0 = acc[0][31:0];
    res.point_1 = acc[1][31:0];
    res.point_2 = acc[2][31:0];
    res.point_3 = acc[3][31:0];
    res.status  = bad;
    return res;
  endfunction

  // Offers one request and returns at the edge that accepts it. Push stays high
  // afterwards so that back-to-back requests need no second assignment.
  task automatic push_request(input req_t r);
    if (jitter && $urandom_range(0, 4) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    push  <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    case (cmd_e'(r.command))
      CMD_KNOT: begin
        if (r.dim_index < MaxParamDims && r.entry_index < MaxKnots)
          knot_mem[r.dim_index * MaxKnots + r.entry_index] = r.load_value;
      end
      CMD_CTRL: begin
        ctrl_mem[r.entry_index * MaxCtrlDims + r.component] = r.load_value;
        ctrl_written[r.entry_index] = 1'b1;
      end
      CMD_EVAL: spline_values.push_back(evaluate_point(r));
      default: ;
    endcase
  endtask

  function automatic req_t load_req(input cmd_e cmd, input int dim, input int entry,
                                    input int comp, input logic [31:0] value);
    req_t r;
    r = '0;
    r.command     = cmd;
    r.dim_index   = dim;
    r.entry_index = entry;
    r.component   = comp;
    r.load_value  = value;
    r.coord_0     = $urandom;
    r.coord_1     = $urandom;
    r.coord_2     = $urandom;
    return r;
  endfunction

  // An evaluate request first loads every control point it will read that has
  // never been written, since the block's stores start out undefined.
  task automatic send(input req_t r);
    res_t probe;
    int   pts [$];
    requests_sent++;
    if (r.command == CMD_EVAL) begin
      unwritten_points.delete();
      probe = evaluate_point(r);
      pts = unwritten_points;
      foreach (pts[i]) begin
        if (!ctrl_written[pts[i]]) begin
          for (int c = 0; c < MaxCtrlDims; c++)
            push_request(load_req(CMD_CTRL, 0, pts[i], c, $urandom));
        end
      end
    end
    push_request(r);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (spline_values.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input int value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    cfg_val[idx] = value & cfg_mask[idx];
    @(posedge clk_i);
  endtask

  task automatic set_config(input int pd, input int cd, input int d0, input int d1,
                            input int d2, input int n0, input int n1, input int n2);
    wait_drained();
    write_reg(REG_PARAM_DIMS, pd);
    write_reg(REG_CTRL_DIMS, cd);
    write_reg(REG_DEGREE0, d0);
    write_reg(REG_DEGREE1, d1);
    write_reg(REG_DEGREE2, d2);
    write_reg(REG_KNOTS0, n0);
    write_reg(REG_KNOTS1, n1);
    write_reg(REG_KNOTS2, n2);
  endtask

  // Writes n ascending knots to one dimension. Style 1 repeats knots often, which
  // gives zero-width spans, and style 2 stretches the knots over the whole range.
  task automatic load_knots(input int s, input int n, input int style);
    longint v, step;
    v = $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
    if (style == 2) v = -64'sd2147483648;
    step = (64'sd4294967295) / (n - 1);
    for (int i = 0; i < n; i++) begin
      if (style == 2 && i == n - 1) v = 64'sd2147483647;
      send(load_req(CMD_KNOT, s, i, 0, v[31:0]));
      if (style == 2) v += step;
      else if (!(style == 1 && $urandom_range(0, 2) == 0) && $urandom_range(0, 7) != 0)
        v += $urandom_range(1, 32'h0004_0000);
    end
  endtask

  task automatic load_used_knots(input int style);
    int n;
    for (int s = 0; s < MaxParamDims; s++) begin
      n = cfg_val[REG_KNOTS0 + s];
      if (n < 2) n = 2;
      if (n > MaxKnots) n = MaxKnots;
      load_knots(s, n, style);
    end
  endtask

  // A coordinate inside the knot range of dimension s, often right on a knot.
  function automatic logic [31:0] coord_inside(input int s);
    longint lo, hi, span;
    longint unsigned rnd;
    int n;
    n = cfg_val[REG_KNOTS0 + s];
    if (n < 2) n = 2;
    if (n > MaxKnots) n = MaxKnots;
    lo = knot_mem[s * MaxKnots];
    hi = knot_mem[s * MaxKnots + n - 1];
    if (hi <= lo) return $urandom;
    case ($urandom_range(0, 5))
      0: return lo[31:0];
      1: return hi[31:0];
      2: return knot_mem[s * MaxKnots + $urandom_range(0, n - 1)];
      default: begin
        rnd  = {$urandom, $urandom};
        span = hi - lo + 1;
        lo  += longint'(rnd % longint'(span));
        return lo[31:0];
      end
    endcase
  endfunction

  function automatic req_t eval_req(input bit inside_range);
    req_t r;
    r = load_req(CMD_EVAL, $urandom, $urandom, $urandom, $urandom);
    if (inside_range) begin
      r.coord_0 = coord_inside(0);
      r.coord_1 = coord_inside(1);
      r.coord_2 = coord_inside(2);
    end
    return r;
  endfunction

  task automatic test_reset_defaults();
    req_t r;
    for (int s = 0; s < MaxParamDims; s++) load_knots(s, MaxKnots, 0);
    r = eval_req(1'b0);
    r.coord_0 = knot_mem[0];
    send(r);
    r.coord_0 = knot_mem[1];
    send(r);
    r.coord_0 = knot_mem[0] - 1;
    send(r);
    r.coord_0 = knot_mem[1] + 1;
    send(r);
    send(load_req(CMD_NONE, 0, 0, 0, $urandom));
    send(load_req(CMD_KNOT, 3, 5, 0, $urandom));
    send(load_req(CMD_KNOT, 1, 4095, 0, $urandom));
    send(eval_req(1'b1));
  endtask

  // Clamped register values, repeated knots, unused components, saturated sums.
  task automatic test_special_cases();
    req_t r;
    set_config(0, 0, 3, 0, 0, 0, 2, 2);
    load_knots(0, 2, 0);
    send(eval_req(1'b1));
    send(load_req(CMD_KNOT, 0, 1, 0, knot_mem[0]));
    send(eval_req(1'b0));
    set_config(1, 2, 3, 0, 0, 9, 2, 2);
    load_knots(0, 9, 1);
    for (int i = 0; i < 4; i++) send(eval_req(1'b1));
    set_config(2, 7, 2, 1, 0, 8, 5, 2);
    load_knots(0, 8, 2);
    load_knots(1, 5, 0);
    for (int i = 0; i < 3; i++) send(eval_req(1'b1));
    r = eval_req(1'b1);
    r.coord_1 = 32'sh8000_0000;
    send(r);
    r.coord_1 = 32'sh7fff_ffff;
    send(r);
    // Near the top of the knot range the flat control index passes the store.
    set_config(2, 4, 7, 7, 0, 127, 64, 2);
    load_knots(0, MaxKnots, 0);
    load_knots(1, MaxKnots, 0);
    r = eval_req(1'b1);
    r.coord_0 = knot_mem[MaxKnots - 1];
    send(r);
  endtask

  task automatic test_largest_sizes();
    set_config(3, 4, 7, 7, 7, 2, 2, 2);
    load_used_knots(0);
    for (int i = 0; i < 3; i++) send(eval_req(1'b1));
    set_config(3, 3, 7, 7, 7, 64, 64, 64);
    load_used_knots(0);
    send(eval_req(1'b1));
  endtask

  task automatic random_phase(input int count);
    int pick;
    req_t r;
    set_config($urandom_range(0, 3), $urandom_range(0, 7), $urandom_range(0, 2),
               $urandom_range(0, 2), $urandom_range(0, 1), $urandom_range(2, 10),
               $urandom_range(2, 6), $urandom_range(2, 4));
    if ($urandom_range(0, 9) == 0) write_reg(REG_DEGREE0, $urandom_range(3, 7));
    load_used_knots($urandom_range(0, 2));
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        send(eval_req($urandom_range(0, 9) != 0));
      end else if (pick < 72) begin
        send(load_req(CMD_CTRL, $urandom, $urandom_range(0, 4095), $urandom, $urandom));
      end else if (pick < 76) begin
        send(load_req(CMD_KNOT, $urandom_range(0, 2), $urandom_range(0, 63), 0, $urandom));
      end else begin
        r = load_req(CMD_KNOT, 3, $urandom, $urandom, $urandom);
        if ($urandom_range(0, 1) == 0) r.command = CMD_NONE;
        if ($urandom_range(0, 1) == 0) begin
          r.dim_index   = $urandom_range(0, 2);
          r.entry_index = $urandom_range(MaxKnots, 4095);
        end
        push_request(r);
      end
    end
  endtask

  task automatic test_random();
    while (requests_sent < 1000) random_phase($urandom_range(20, 60));
  endtask

  // The receiver stops popping while evaluations keep coming, so the input
  // queue fills and full holds the sender; then everything is drained.
  task automatic test_backpressure();
    set_config(1, 4, 1, 0, 0, 4, 2, 2);
    load_used_knots(0);
    jitter = 1'b0;
    hold_request = 600;
    for (int i = 0; i < 12; i++) send(eval_req(1'b1));
    wait_drained();
    jitter = 1'b1;
  endtask

  task automatic test_final_burst();
    jitter = 1'b0;
    random_phase(60);
  endtask

  // Results are compared at the edge that pops them.
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && pop && !empty) begin
      if (spline_values.size() == 0) begin
        $error("result popped with none expected");
        errors++;
      end else begin
        want = spline_values.pop_front();
        if (res_o.point_0 !== want.point_0) begin
          $error("point_0 expected %0d got %0d", want.point_0, res_o.point_0);
          errors++;
        end
        if (res_o.point_1 !== want.point_1) begin
          $error("point_1 expected %0d got %0d", want.point_1, res_o.point_1);
          errors++;
        end
        if (res_o.point_2 !== want.point_2) begin
          $error("point_2 expected %0d got %0d", want.point_2, res_o.point_2);
          errors++;
        end
        if (res_o.point_3 !== want.point_3) begin
          $error("point_3 expected %0d got %0d", want.point_3, res_o.point_3);
          errors++;
        end
        if (res_o.status !== want.status) begin
          $error("status expected %0d got %0d", want.status, res_o.status);
          errors++;
        end
      end
    end
  end

  // The receiver pops in bursts with random stalls, and holds off for a long
  // stretch when the back-pressure test asks for it.
  always @(posedge clk_i) begin
    static int hold_left = 0;
    static int stall_left = 0;
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
      if (jitter && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 17);
    end
  end

  // Watchdog: counts edges at which nothing moves on either side.
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || psel) idle_count = 0;
    else idle_count++;
    if (idle_count >= StallLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    errors        = 0;
    requests_sent = 0;
    jitter        = 1'b1;
    hold_request  = 0;
    idle_count    = 0;
    rst_ni  <= 1'b0;
    push    <= 1'b0;
    req_i   <= '0;
    pop     <= 1'b0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_special_cases();
    test_largest_sizes();
    test_backpressure();
    test_random();
    test_final_burst();
    wait_drained();
    repeat (50) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
